// ----- rtl/char_lcd_nibble_writer_unit_assert.svh -----
// Assertion macros shared by the checker of the character LCD nibble writer.
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH

// Implication to the next cycle, checked only outside reset.
`define CLNW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clnw assertion failed");

// Implication to the next cycle, checked during reset as well.
`define CLNW_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("clnw assertion failed during reset");

`endif

// ----- rtl/clnw_pkg.sv -----
// ----------------------------------------------------------------------------
// clnw_pkg
// Types and constants shared by the character LCD nibble writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

  localparam int COL_W      = 5;
  localparam int STEP_W     = COL_W + 1;
  localparam int SCRIPT_LEN = 16;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_LINE = 2'd1;
  localparam logic [1:0] MODE_CHAR = 2'd2;
  localparam logic [1:0] MODE_PAD  = 2'd3;

  localparam logic [7:0] PAD_RESET = 8'h10;
  localparam logic [7:0] CMD_DDRAM = 8'h80;

  typedef enum logic [1:0] {
    JK_SCRIPT = 2'd0,
    JK_CMD    = 2'd1,
    JK_DATA   = 2'd2,
    JK_PAD    = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [7:0]       code;
    logic [COL_W-1:0] cols;
  } job_t;

  // Power-up script: function set 4-bit twice over, display on, clear, entry mode.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd5:                 nib = 4'h3;
      4'd1, 4'd3, 4'd6, 4'd8:     nib = 4'h2;
      4'd2, 4'd4, 4'd7, 4'd9:     nib = 4'h8;
      4'd11:                      nib = 4'hC;
      4'd13:                      nib = 4'h1;
      4'd15:                      nib = 4'h6;
      default:                    nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/clnw_queue.sv -----
// ----------------------------------------------------------------------------
// clnw_queue
// Two-entry job queue between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  clnw_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output clnw_pkg::job_t rd_job,
  output logic          empty
);
  import clnw_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/clnw_front.sv -----
// ----------------------------------------------------------------------------
// clnw_front
// Accepts request items, tracks the column and turns each item into a job, but drops a finish on a complete line.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_front #(
  parameter int LINE_WIDTH       = 16,
  parameter int SECOND_LINE_BASE = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     mode,
  input  logic           line_select,
  input  logic [7:0]     char_code,
  input  logic           q_full,
  output logic           job_push,
  output clnw_pkg::job_t job
);
  import clnw_pkg::*;

  localparam logic [COL_W-1:0] LW    = COL_W'(LINE_WIDTH);
  localparam logic [6:0]       BASE7 = 7'(SECOND_LINE_BASE % 128);

  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             accept;
  logic             line_done;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign line_done = (column == LW);

  always_comb begin
    job.kind    = JK_PAD;
    job.code    = char_code;
    job.cols    = LW - column;
    job_push    = accept;
    column_next = column;
    case (mode)
      MODE_INIT: begin
        job.kind    = JK_SCRIPT;
        column_next = LW;
      end
      MODE_LINE: begin
        job.kind    = JK_CMD;
        job.code    = line_select ? (CMD_DDRAM | {1'b0, BASE7}) : CMD_DDRAM;
        column_next = '0;
      end
      MODE_CHAR: begin
        job.kind    = JK_DATA;
        column_next = line_done ? LW : column + COL_W'(1);
      end
      default: begin
        // drop a finish on a complete line: it makes no writes
        job_push    = accept && !line_done;
        column_next = LW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= LW;
    end else if (accept) begin
      column <= column_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/clnw_back.sv -----
// ----------------------------------------------------------------------------
// clnw_back
// Carries out queued jobs, one nibble write per cycle into the output register while pop keeps up.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  clnw_pkg::job_t job,
  output logic           q_pop,
  input  logic [7:0]     pad_code,
  output logic           empty,
  input  logic           pop,
  output logic           reg_select,
  output logic [3:0]     nibble,
  output logic           last
);
  import clnw_pkg::*;

  logic [STEP_W-1:0] step;
  logic              out_valid;
  logic              adv;
  logic [7:0]        byte_sel;
  logic [3:0]        byte_nib;
  logic              rs_cur;
  logic [3:0]        nib_cur;
  logic              last_cur;

  assign empty    = !out_valid;
  assign adv      = !q_empty && (!out_valid || pop);
  assign q_pop    = adv && last_cur;
  assign byte_sel = (job.kind == JK_PAD) ? pad_code : job.code;
  assign byte_nib = step[0] ? byte_sel[3:0] : byte_sel[7:4];

  always_comb begin
    rs_cur   = 1'b1;
    nib_cur  = byte_nib;
    last_cur = (step == STEP_W'(1));
    case (job.kind)
      JK_SCRIPT: begin
        rs_cur   = 1'b0;
        nib_cur  = init_nibble(step[3:0]);
        last_cur = (step == STEP_W'(SCRIPT_LEN - 1));
      end
      JK_CMD: begin
        rs_cur = 1'b0;
      end
      JK_DATA: begin
        rs_cur = 1'b1;
      end
      default: begin
        last_cur = step[0] && (step[STEP_W-1:1] == job.cols - COL_W'(1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reg_select <= rs_cur;
      nibble     <= nib_cur;
      last       <= last_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (adv) begin
      out_valid <= 1'b1;
      // advance within the job, restart for the next one
      step      <= last_cur ? '0 : step + STEP_W'(1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/char_lcd_nibble_writer_unit.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// 4-bit bus write sequencer for a two-line character display.
// ----------------------------------------------------------------------------
// Request items enter on push/full: mode, line_select, char_code. An item is
// taken when push is high and full is low. Nibble writes leave on empty/pop:
// reg_select, nibble and last are valid while empty is low and are taken when
// pop is high. last marks the final write of an item.
// Init yields 16 writes, start line and character 2 each, finish line
// 2 * (LINE_WIDTH - column) writes, none on a complete line.
// The first write of an item passes through the job queue and then the output
// register if the back end is idle. The back end sequencer makes one nibble
// write per cycle while pop keeps up; the job in progress holds one slot of
// the two-entry job queue, so the front takes one further item meanwhile.
// The user writes pad_code through cfg_we/cfg_data while the block is idle; the block does not enforce it.
// Reset empties the queue and output register, sets pad_code to 0x10 and marks
// the current line complete. When pop stays low the write on the ports holds,
// the back end stops and full rises once the job queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer_unit #(
  parameter int LINE_WIDTH       = 16,
  parameter int SECOND_LINE_BASE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode,
  input  logic       line_select,
  input  logic [7:0] char_code,
  output logic       empty,
  input  logic       pop,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic       last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  import clnw_pkg::*;

  logic [7:0] pad_code;
  logic       job_push;
  job_t       front_job;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  job_t       head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_code <= PAD_RESET;
    end else if (cfg_we) begin
      pad_code <= cfg_data;
    end
  end

  clnw_front #(
    .LINE_WIDTH       (LINE_WIDTH),
    .SECOND_LINE_BASE (SECOND_LINE_BASE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .line_select (line_select),
    .char_code   (char_code),
    .q_full      (q_full),
    .job_push    (job_push),
    .job         (front_job)
  );

  clnw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (front_job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (head_job),
    .empty  (q_empty)
  );

  clnw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .job        (head_job),
    .q_pop      (q_pop),
    .pad_code   (pad_code),
    .empty      (empty),
    .pop        (pop),
    .reg_select (reg_select),
    .nibble     (nibble),
    .last       (last)
  );

endmodule

`default_nettype wire

// ----- rtl/clnw_checker.sv -----
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks on the character LCD nibble writer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_writer_unit_assert.svh"

module clnw_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       reg_select,
  input logic [3:0] nibble,
  input logic       last
);

  // nothing to deliver and room for items right after reset
  `CLNW_ASSERT_NEXT_ANY(a_reset_empty, rst, empty)
  `CLNW_ASSERT_NEXT_ANY(a_reset_not_full, rst, !full)

  // a stalled write holds on the ports
  `CLNW_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(nibble) && $stable(reg_select) && $stable(last))

  // output can only appear once an item has been offered
  `CLNW_ASSERT_NEXT(a_no_idle_output, empty && !push && $past(empty) && $past(!push) && $past(!push, 2), empty)

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .reg_select (reg_select),
  .nibble     (nibble),
  .last       (last)
);

`default_nettype wire
